@@ hw/rtl/dfr_pkg.sv @@
// ----------------------------------------------------------------------------
// dfr_pkg
// Types and constants shared by the datagram receive filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

   localparam int SLOT_COUNT = 4;

   localparam logic [7:0] HEADER_BYTES   = 8'd4;
   localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
   localparam logic [7:0] ZERO_BYTE      = 8'h00;
   localparam logic [7:0] COUNT_MAX      = 8'hFF;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT   = 2'd0,
      VERDICT_SHORT    = 2'd1,
      VERDICT_XOR_ERR  = 2'd2,
      VERDICT_NOT_HERE = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      REG_OWN_ADDRESS  = 3'd0,
      REG_LISTENER_CNT = 3'd1,
      REG_PORT_ZERO    = 3'd2,
      REG_PORT_ONE     = 3'd3,
      REG_PORT_TWO     = 3'd4,
      REG_PORT_THREE   = 3'd5,
      REG_SPARE_SIX    = 3'd6,
      REG_SPARE_SEVEN  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [7:0]                  own_address;
      logic [2:0]                  listener_count;
      logic [SLOT_COUNT-1:0][7:0]  listener_ports;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

endpackage

`default_nettype wire

@@ hw/rtl/dfr_if.sv @@
// ----------------------------------------------------------------------------
// dfr_req_if / dfr_rsp_if
// Valid/ready channels for input bytes and filter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       payload_valid;
   logic       packet_done;
   logic [1:0] verdict;
   logic [3:0] listener_hits;
   logic [7:0] dest_address;
   logic [7:0] source_address;
   logic [7:0] dest_port;
   logic [7:0] payload_length;

   modport source (
      output valid, output payload_byte, output payload_valid, output packet_done,
      output verdict, output listener_hits, output dest_address, output source_address,
      output dest_port, output payload_length, input ready
   );
   modport sink (
      input valid, input payload_byte, input payload_valid, input packet_done,
      input verdict, input listener_hits, input dest_address, input source_address,
      input dest_port, input payload_length, output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/dfr_csr.sv @@
// ----------------------------------------------------------------------------
// dfr_csr
// APB-style register file: own address, listener count and listener ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [4:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic      [31:0]   csr_prdata,
   output logic               csr_pready,
   output dfr_pkg::cfg_type   cfg
);
   import dfr_pkg::*;

   logic [7:0]                 own_address_ff;
   logic [2:0]                 listener_count_ff;
   logic [SLOT_COUNT-1:0][7:0] port_ff;
   logic                       write_en;
   reg_index_type              reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff    <= '0;
         listener_count_ff <= '0;
         port_ff           <= '0;
      end else if (write_en) begin
         case (reg_index)
            REG_OWN_ADDRESS:  own_address_ff    <= csr_pwdata[7:0];
            REG_LISTENER_CNT: listener_count_ff <= csr_pwdata[2:0];
            REG_PORT_ZERO:    port_ff[0]        <= csr_pwdata[7:0];
            REG_PORT_ONE:     port_ff[1]        <= csr_pwdata[7:0];
            REG_PORT_TWO:     port_ff[2]        <= csr_pwdata[7:0];
            REG_PORT_THREE:   port_ff[3]        <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_index)
         REG_OWN_ADDRESS:  csr_prdata[7:0] = own_address_ff;
         REG_LISTENER_CNT: csr_prdata[2:0] = listener_count_ff;
         REG_PORT_ZERO:    csr_prdata[7:0] = port_ff[0];
         REG_PORT_ONE:     csr_prdata[7:0] = port_ff[1];
         REG_PORT_TWO:     csr_prdata[7:0] = port_ff[2];
         REG_PORT_THREE:   csr_prdata[7:0] = port_ff[3];
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.own_address    = own_address_ff;
   assign cfg.listener_count = listener_count_ff;
   assign cfg.listener_ports = port_ff;

endmodule

`default_nettype wire

@@ hw/rtl/dfr_filter.sv @@
// ----------------------------------------------------------------------------
// dfr_filter
// Packet state (XOR, byte index, header capture), verdict logic and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_filter #(
   parameter int MAX_LISTENERS    = 4,
   parameter int MAX_PACKET_BYTES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dfr_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   input  wire dfr_pkg::item_type in_item,
   output logic                   in_ready,
   dfr_rsp_if.source              rsp_if
);
   import dfr_pkg::*;

   localparam int PLEN_CAP_INT = (MAX_PACKET_BYTES - 4 > 255) ? 255 : MAX_PACKET_BYTES - 4;
   localparam logic [7:0] PLEN_CAP = 8'(PLEN_CAP_INT);

   logic [7:0] xor_ff, xor_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] dest_ff, dest_in;
   logic [7:0] src_ff, src_in;
   logic [7:0] port_ff, port_in;

   logic        rsp_valid_ff;
   logic [7:0]  payload_byte_ff, payload_byte_in;
   logic        payload_valid_ff, payload_valid_in;
   logic        done_ff, done_in;
   verdict_type verdict_ff, verdict_in;
   logic [3:0]  hits_ff, hits_in;
   logic [7:0]  rsp_dest_ff, rsp_dest_in;
   logic [7:0]  rsp_src_ff, rsp_src_in;
   logic [7:0]  rsp_port_ff, rsp_port_in;
   logic [7:0]  plen_ff, plen_in;

   logic       advance;
   logic [7:0] b;
   logic [7:0] x;
   logic       short_pkt;
   logic [7:0] plen_raw;
   logic [3:0] match;

   assign in_ready = !rsp_valid_ff || rsp_if.ready;
   assign advance  = in_valid && in_ready;
   assign b        = in_item.data_byte;
   assign x        = xor_ff ^ b;

   always_comb begin
      dest_in = dest_ff;
      src_in  = src_ff;
      port_in = port_ff;
      if (count_ff == 8'd0) begin
         dest_in = b;
         src_in  = ZERO_BYTE;
         port_in = ZERO_BYTE;
      end else if (count_ff == 8'd1) begin
         src_in = b;
      end else if (count_ff == 8'd2) begin
         port_in = b;
      end
   end

   // Length is index + 1, so fewer than four bytes means index below three
   assign short_pkt = count_ff < (HEADER_BYTES - 8'd1);
   assign plen_raw  = count_ff - (HEADER_BYTES - 8'd1);

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         match[i] = (i < MAX_LISTENERS) && (int'(cfg.listener_count) > i)
                    && (cfg.listener_ports[i] == port_in);
      end
   end

   always_comb begin
      payload_valid_in = count_ff >= HEADER_BYTES;
      payload_byte_in  = payload_valid_in ? b : ZERO_BYTE;
      done_in          = in_item.last_byte;
      verdict_in       = VERDICT_ACCEPT;
      hits_in          = '0;
      rsp_dest_in      = ZERO_BYTE;
      rsp_src_in       = ZERO_BYTE;
      rsp_port_in      = ZERO_BYTE;
      plen_in          = ZERO_BYTE;
      if (in_item.last_byte) begin
         if (short_pkt) begin
            verdict_in = VERDICT_SHORT;
         end else if (x != ZERO_BYTE) begin
            verdict_in = VERDICT_XOR_ERR;
         end else if (dest_in != cfg.own_address && dest_in != BROADCAST_ADDR) begin
            verdict_in = VERDICT_NOT_HERE;
         end else begin
            hits_in = match;
         end
         rsp_dest_in = dest_in;
         rsp_src_in  = src_in;
         rsp_port_in = port_in;
         if (!short_pkt) begin
            plen_in = (plen_raw > PLEN_CAP) ? PLEN_CAP : plen_raw;
         end
      end
   end

   always_comb begin
      if (in_item.last_byte) begin
         xor_in   = ZERO_BYTE;
         count_in = ZERO_BYTE;
      end else begin
         xor_in   = x;
         count_in = (count_ff < COUNT_MAX) ? count_ff + 8'd1 : count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_ff   <= '0;
         count_ff <= '0;
         dest_ff  <= '0;
         src_ff   <= '0;
         port_ff  <= '0;
      end else if (advance) begin
         xor_ff   <= xor_in;
         count_ff <= count_in;
         dest_ff  <= dest_in;
         src_ff   <= src_in;
         port_ff  <= port_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         payload_byte_ff  <= payload_byte_in;
         payload_valid_ff <= payload_valid_in;
         done_ff          <= done_in;
         verdict_ff       <= verdict_in;
         hits_ff          <= hits_in;
         rsp_dest_ff      <= rsp_dest_in;
         rsp_src_ff       <= rsp_src_in;
         rsp_port_ff      <= rsp_port_in;
         plen_ff          <= plen_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.payload_byte   = payload_byte_ff;
   assign rsp_if.payload_valid  = payload_valid_ff;
   assign rsp_if.packet_done    = done_ff;
   assign rsp_if.verdict        = verdict_ff;
   assign rsp_if.listener_hits  = hits_ff;
   assign rsp_if.dest_address   = rsp_dest_ff;
   assign rsp_if.source_address = rsp_src_ff;
   assign rsp_if.dest_port      = rsp_port_ff;
   assign rsp_if.payload_length = plen_ff;

endmodule

`default_nettype wire

@@ hw/rtl/datagram_receive_filter_core.sv @@
// ----------------------------------------------------------------------------
// datagram_receive_filter_core
// Receive filter for deframed datagrams: payload pass-through and verdict.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle while results are taken and returns one
// result item per byte, each byte passing the input register and then the
// result register, with the XOR, byte index, header capture and verdict
// done in a single pass between them. A new byte can enter every cycle as
// long as results are taken; when a result waits, the input register takes
// one more byte and then input stalls until the result is taken. On the
// byte marked last the result carries the verdict, the listener hit mask,
// the header fields and the saturated payload length; otherwise those
// fields are zero. Registers: own_address at 0x00, listener_count at 0x04,
// listener ports zero to three at 0x08 to 0x14; write them while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module datagram_receive_filter_core #(
   parameter int MAX_LISTENERS    = 4,
   parameter int MAX_PACKET_BYTES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   dfr_req_if.sink          req_if,
   dfr_rsp_if.source        rsp_if,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import dfr_pkg::*;

   cfg_type  cfg;
   logic     s1_valid_ff;
   item_type s1_item_ff;
   logic     filt_ready;

   dfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_if.ready = !s1_valid_ff || filt_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (filt_ready) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Hold the item until the filter takes it
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_item_ff.data_byte <= req_if.data_byte;
         s1_item_ff.last_byte <= req_if.last_byte;
      end
   end

   dfr_filter #(
      .MAX_LISTENERS    (MAX_LISTENERS),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_filter (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (s1_valid_ff),
      .in_item  (s1_item_ff),
      .in_ready (filt_ready),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire
